FILE: src/iqlpc_pkg.sv
package iqlpc_pkg;

  // Default sample width and the fixed field widths of the result.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MAG_W            = 16;
  localparam int PHASOR_W         = 16;

  // The quotient magnitude never exceeds the Q15 one, so 15 bits suffice.
  localparam int QUOT_W = 15;

  // Q15 near-one scale factor and the reset floor.
  localparam logic [QUOT_W-1:0] Q15_ONE       = 15'd32767;
  localparam logic [MAG_W-1:0]  MIN_MAG_RESET = 16'd100;

  // Sideband that rides along the divider pipeline.
  typedef struct packed {
    logic [MAG_W-1:0] mag_sat;
    logic             too_small;
    logic             zero;
    logic             cos_neg;
    logic             sin_neg;
  } dv_side_t;

endpackage

FILE: src/iqlpc_sqrt.sv
module iqlpc_sqrt #(
  parameter int SW   = iqlpc_pkg::SAMPLE_WIDTH_DEF,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [2*SW-1:0]   in_x,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_vld,
  output logic [SW-1:0]     out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int RW = 2*SW + 1;

  logic            vld_r  [SW];
  logic [RW-1:0]   rem_r  [SW];
  logic [SW-1:0]   root_r [SW];
  logic [SB_W-1:0] sb_r   [SW];

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < SW; k++) begin : g_stage
    localparam int B = SW - 1 - k;

    logic            vld_in;
    logic [RW-1:0]   rem_in;
    logic [SW-1:0]   root_in;
    logic [SB_W-1:0] sb_in;
    logic [RW-1:0]   trial;
    logic [RW-1:0]   rem_nxt;
    logic [SW-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = {1'b0, in_x};
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    // The growth of the square when this root bit is set.
    assign trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2*B));

    always_comb begin
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = root_in | (SW'(1) << B);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sb_r[k]   <= sb_in;
      end
    end
  end

  assign out_vld  = vld_r[SW-1];
  assign out_root = root_r[SW-1];
  assign out_sb   = sb_r[SW-1];

endmodule

FILE: src/iqlpc_div.sv
module iqlpc_div #(
  parameter int NW = iqlpc_pkg::SAMPLE_WIDTH_DEF + iqlpc_pkg::QUOT_W,
  parameter int MW = iqlpc_pkg::MAG_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [NW-1:0]                 in_num_a,
  input  logic [NW-1:0]                 in_num_b,
  input  logic [MW-1:0]                 in_den,
  input  iqlpc_pkg::dv_side_t           in_side,
  output logic                          out_vld,
  output logic [iqlpc_pkg::QUOT_W-1:0]  out_quo_a,
  output logic [iqlpc_pkg::QUOT_W-1:0]  out_quo_b,
  output iqlpc_pkg::dv_side_t           out_side
);

  localparam int QW = iqlpc_pkg::QUOT_W;
  localparam int CW = NW + MW + 1;

  logic                vld_r   [QW];
  logic [NW-1:0]       rema_r  [QW];
  logic [NW-1:0]       remb_r  [QW];
  logic [QW-1:0]       quoa_r  [QW];
  logic [QW-1:0]       quob_r  [QW];
  logic [MW-1:0]       den_r   [QW];
  iqlpc_pkg::dv_side_t side_r  [QW];

  // Restoring division, one quotient bit of both dividends per stage.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;

    logic                vld_in;
    logic [NW-1:0]       rema_in, remb_in;
    logic [QW-1:0]       quoa_in, quob_in;
    logic [MW-1:0]       den_in;
    iqlpc_pkg::dv_side_t side_in;
    logic [CW-1:0]       shd;
    logic [NW-1:0]       rema_nxt, remb_nxt;
    logic [QW-1:0]       quoa_nxt, quob_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rema_in = in_num_a;
      assign remb_in = in_num_b;
      assign quoa_in = '0;
      assign quob_in = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rema_in = rema_r[k-1];
      assign remb_in = remb_r[k-1];
      assign quoa_in = quoa_r[k-1];
      assign quob_in = quob_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign shd = CW'(den_in) << B;

    always_comb begin
      rema_nxt = rema_in;
      quoa_nxt = quoa_in;
      remb_nxt = remb_in;
      quob_nxt = quob_in;
      if (CW'(rema_in) >= shd) begin
        rema_nxt = NW'(CW'(rema_in) - shd);
        quoa_nxt = quoa_in | (QW'(1) << B);
      end
      if (CW'(remb_in) >= shd) begin
        remb_nxt = NW'(CW'(remb_in) - shd);
        quob_nxt = quob_in | (QW'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rema_r[k] <= rema_nxt;
        remb_r[k] <= remb_nxt;
        quoa_r[k] <= quoa_nxt;
        quob_r[k] <= quob_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld   = vld_r[QW-1];
  assign out_quo_a = quoa_r[QW-1];
  assign out_quo_b = quob_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

FILE: src/iq_loop_phase_calibration_unit.sv
// Channel   Direction  Ports
// in        request    in_valid, in_stall, in_resp_i, in_resp_q
// out       result     out_valid, out_stall, out_magnitude, out_too_small,
//                      out_rot_cos, out_rot_sin
// cfg       write      cfg_wr_en, cfg_wr_data (min_magnitude)
//
// One request enters per cycle while the output is not stalled; each result then passes
// through three input stages, one square-root stage per root bit, a floor stage,
// fifteen divider stages and the output register.
// Reset clears every stage valid bit and loads the floor with 100.
// A stalled output freezes the whole pipeline and holds in_stall high.
module iq_loop_phase_calibration_unit #(
  parameter int SAMPLE_WIDTH = iqlpc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_resp_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_resp_q,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [iqlpc_pkg::MAG_W-1:0]    out_magnitude,
  output logic                           out_too_small,
  output logic signed [iqlpc_pkg::PHASOR_W-1:0] out_rot_cos,
  output logic signed [iqlpc_pkg::PHASOR_W-1:0] out_rot_sin,
  input  logic                           cfg_wr_en,
  input  logic [iqlpc_pkg::MAG_W-1:0]    cfg_wr_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int QW = iqlpc_pkg::QUOT_W;
  localparam int NW = SW + QW;
  localparam int MW = (SW > iqlpc_pkg::MAG_W) ? SW : iqlpc_pkg::MAG_W;
  localparam int PW = iqlpc_pkg::PHASOR_W;
  localparam int SB_W = 2*NW + 2;

  logic en;
  logic [iqlpc_pkg::MAG_W-1:0] min_mag_r;

  // The whole pipeline advances unless the output holds a stalled result.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Floor register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mag_r <= iqlpc_pkg::MIN_MAG_RESET;
    end else if (cfg_wr_en) begin
      min_mag_r <= cfg_wr_data;
    end
  end

  // Stage 0: magnitudes and signs of the samples.
  logic          s0_vld_r;
  logic [SW-1:0] s0_ai_r, s0_aq_r;
  logic          s0_ineg_r, s0_qneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ai_r   <= in_resp_i[SW-1] ? SW'(-in_resp_i) : SW'(in_resp_i);
      s0_aq_r   <= in_resp_q[SW-1] ? SW'(-in_resp_q) : SW'(in_resp_q);
      s0_ineg_r <= in_resp_i[SW-1];
      s0_qneg_r <= in_resp_q[SW-1];
    end
  end

  // Stage 1: squares and scaled dividends.
  logic            s1_vld_r;
  logic [2*SW-1:0] s1_sqi_r, s1_sqq_r;
  logic [NW-1:0]   s1_numi_r, s1_numq_r;
  logic            s1_ineg_r, s1_qneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sqi_r  <= (2*SW)'(s0_ai_r) * (2*SW)'(s0_ai_r);
      s1_sqq_r  <= (2*SW)'(s0_aq_r) * (2*SW)'(s0_aq_r);
      s1_numi_r <= NW'(s0_ai_r) * NW'(iqlpc_pkg::Q15_ONE);
      s1_numq_r <= NW'(s0_aq_r) * NW'(iqlpc_pkg::Q15_ONE);
      s1_ineg_r <= s0_ineg_r;
      s1_qneg_r <= s0_qneg_r;
    end
  end

  // Stage 2: sum of squares.
  logic            s2_vld_r;
  logic [2*SW-1:0] s2_sum_r;
  logic [SB_W-1:0] s2_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum_r <= s1_sqi_r + s1_sqq_r;
      s2_sb_r  <= {s1_numi_r, s1_numq_r, s1_ineg_r, s1_qneg_r};
    end
  end

  // Square root pipeline.
  logic            sq_vld;
  logic [SW-1:0]   sq_root;
  logic [SB_W-1:0] sq_sb;

  iqlpc_sqrt #(
    .SW   (SW),
    .SB_W (SB_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_x     (s2_sum_r),
    .in_sb    (s2_sb_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  // Stage 3: apply the floor.
  logic                s3_vld_r;
  logic [MW-1:0]       s3_mag_r;
  logic [NW-1:0]       s3_numi_r, s3_numq_r;
  iqlpc_pkg::dv_side_t s3_side_r;
  logic [MW-1:0]       root_ext, floor_ext, mag_nxt;
  logic                small_nxt;
  iqlpc_pkg::dv_side_t side_nxt;

  always_comb begin
    root_ext  = MW'(sq_root);
    floor_ext = MW'(min_mag_r);
    small_nxt = root_ext < floor_ext;
    mag_nxt   = small_nxt ? floor_ext : root_ext;
    side_nxt.mag_sat = (mag_nxt > MW'(16'hFFFF)) ? 16'hFFFF
                                                  : mag_nxt[iqlpc_pkg::MAG_W-1:0];
    side_nxt.too_small = small_nxt;
    side_nxt.zero      = (mag_nxt == '0);
    side_nxt.cos_neg   = sq_sb[1];
    side_nxt.sin_neg   = !sq_sb[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mag_r  <= mag_nxt;
      s3_numi_r <= sq_sb[SB_W-1 -: NW];
      s3_numq_r <= sq_sb[NW+1 : 2];
      s3_side_r <= side_nxt;
    end
  end

  // Divider pipeline for both phasor components.
  logic                dv_vld;
  logic [QW-1:0]       dv_quo_i, dv_quo_q;
  iqlpc_pkg::dv_side_t dv_side;

  iqlpc_div #(
    .NW (NW),
    .MW (MW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (s3_vld_r),
    .in_num_a  (s3_numi_r),
    .in_num_b  (s3_numq_r),
    .in_den    (s3_mag_r),
    .in_side   (s3_side_r),
    .out_vld   (dv_vld),
    .out_quo_a (dv_quo_i),
    .out_quo_b (dv_quo_q),
    .out_side  (dv_side)
  );

  // Output register: cosine takes the I sign, sine the inverted Q sign; zero divisor gives a zero phasor.
  logic                 out_vld_r;
  logic [PW-1:0]        cos_mag, sin_mag;
  logic [PW-1:0]        cos_nxt, sin_nxt;

  always_comb begin
    cos_mag = PW'(dv_quo_i);
    sin_mag = PW'(dv_quo_q);
    if (dv_side.zero) begin
      cos_nxt = '0;
      sin_nxt = '0;
    end else begin
      cos_nxt = dv_side.cos_neg ? PW'(-cos_mag) : cos_mag;
      sin_nxt = dv_side.sin_neg ? PW'(-sin_mag) : sin_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_magnitude <= dv_side.mag_sat;
      out_too_small <= dv_side.too_small;
      out_rot_cos   <= cos_nxt;
      out_rot_sin   <= sin_nxt;
    end
  end

  assign out_valid = out_vld_r;

  // A held result must freeze the input side.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output stalled");

  // The quotient never reaches full negative scale.
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rot_cos != -16'sd32768) && (out_rot_sin != -16'sd32768))
    else $error("phasor component out of range");

  // A zero magnitude yields a zero phasor.
  a_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_magnitude == '0) |-> (out_rot_cos == '0) && (out_rot_sin == '0))
    else $error("nonzero phasor for zero magnitude");

  // A stalled result stays put for the next cycle.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_magnitude))
    else $error("stalled result changed");

endmodule
